// ===== design/vnr_pkg.sv =====
// Shared constants and types for the vector norm reducer.
package vnr_pkg;

   localparam int SAMPLE_WIDTH = 16;
   localparam int ACC_WIDTH    = 48;
   localparam int RESULT_WIDTH = 49;
   localparam int RSP_DATA_WIDTH = ((RESULT_WIDTH + 7) / 8) * 8;
   localparam int REQ_DATA_WIDTH = ((SAMPLE_WIDTH + 7) / 8) * 8;
   localparam int MAG_WIDTH    = SAMPLE_WIDTH + 1;
   localparam int SQ_WIDTH     = 2 * MAG_WIDTH;
   localparam int ROOT_STEPS   = ACC_WIDTH / 2;
   localparam int ROOT_WIDTH   = ROOT_STEPS;
   localparam int REM_WIDTH    = ROOT_WIDTH + 3;
   localparam int STEP_CNT_WIDTH = $clog2(ROOT_STEPS);

   localparam logic [1:0] MODE_L1   = 2'd0;
   localparam logic [1:0] MODE_L2   = 2'd1;
   localparam logic [1:0] MODE_LINF = 2'd2;
   localparam logic [1:0] MODE_SMAX = 2'd3;

   typedef struct packed {
      logic accept;     // take the sample on the input
      logic root_step;  // one square root iteration
      logic load_out;   // move the result into the output register
   } vnr_cmd_type;

   typedef struct packed {
      logic is_l2;
   } vnr_status_type;

endpackage

// ===== design/vnr_ctrl.sv =====
// Sequencing of accumulation, square root iterations and result hand-off.
module vnr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   input  logic                    req_tlast,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  vnr_pkg::vnr_status_type status,
   output vnr_pkg::vnr_cmd_type    cmd
);

   localparam logic [1:0] S_RUN  = 2'd0;
   localparam logic [1:0] S_ROOT = 2'd1;
   localparam logic [1:0] S_LOAD = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [vnr_pkg::STEP_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic take;
   logic slot_free;

   assign req_tready = (state_ff == S_RUN);
   assign take       = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         S_RUN: begin
            if (take) begin
               cmd.accept = 1'b1;
               cnt_in     = '0;
               if (req_tlast) begin
                  state_in = status.is_l2 ? S_ROOT : S_LOAD;
               end
            end
         end
         S_ROOT: begin
            cmd.root_step = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == vnr_pkg::STEP_CNT_WIDTH'(vnr_pkg::ROOT_STEPS - 1)) begin
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            if (slot_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_RUN;
            end
         end
         default: begin
            state_in = S_RUN;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_RUN;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_short_path: assert property (@(posedge clock) disable iff (reset)
      (take && req_tlast && !status.is_l2) |=> (state_ff == S_LOAD))
      else $error("non-L2 word with last did not go to load");

   a_root_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROOT && state_in == S_LOAD) |->
      (cnt_ff == vnr_pkg::STEP_CNT_WIDTH'(vnr_pkg::ROOT_STEPS - 1)))
      else $error("square root left early");

   a_valid_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_LOAD))
      else $error("output valid without a load");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_tready))
      else $error("output register overwritten");

endmodule

// ===== design/vnr_datapath.sv =====
// Accumulator, mode register, square root unit and output register.
module vnr_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [1:0]                            csr_wr_data,
   input  logic signed [vnr_pkg::SAMPLE_WIDTH-1:0] sample,
   input  vnr_pkg::vnr_cmd_type                  cmd,
   output vnr_pkg::vnr_status_type               status,
   output logic [vnr_pkg::RESULT_WIDTH-1:0]      result_value,
   output logic                                  saturated
);

   logic [1:0] mode_ff;
   logic [vnr_pkg::ACC_WIDTH-1:0] acc_ff, acc_in;
   logic clip_ff, clip_in;
   logic at_start_ff, at_start_in;
   logic [vnr_pkg::REM_WIDTH-1:0]  rem_ff, rem_in;
   logic [vnr_pkg::ROOT_WIDTH-1:0] root_ff, root_in;
   logic [vnr_pkg::RESULT_WIDTH-1:0] result_ff, result_in;
   logic sat_ff;

   logic neg;
   logic [vnr_pkg::MAG_WIDTH-1:0] mag;
   logic [vnr_pkg::SQ_WIDTH-1:0]  sq;
   logic [vnr_pkg::ACC_WIDTH-1:0] base, addend, sext;
   logic [vnr_pkg::ACC_WIDTH:0]   sum;
   logic base_clip;
   logic [vnr_pkg::REM_WIDTH-1:0] rem_shift, trial;
   logic ge;

   assign status.is_l2 = (mode_ff == vnr_pkg::MODE_L2);

   assign neg  = sample[vnr_pkg::SAMPLE_WIDTH-1];
   assign mag  = neg ? (vnr_pkg::MAG_WIDTH'(unsigned'(~sample)) + 1'b1)
                     : vnr_pkg::MAG_WIDTH'(unsigned'(sample));
   assign sq   = vnr_pkg::SQ_WIDTH'(mag) * vnr_pkg::SQ_WIDTH'(mag);
   assign sext = vnr_pkg::ACC_WIDTH'(sample);
   assign base      = at_start_ff ? '0 : acc_ff;
   assign base_clip = at_start_ff ? 1'b0 : clip_ff;
   assign addend = (mode_ff == vnr_pkg::MODE_L1) ? vnr_pkg::ACC_WIDTH'(mag)
                                                 : vnr_pkg::ACC_WIDTH'(sq);
   assign sum = {1'b0, base} + {1'b0, addend};

   assign rem_shift = {rem_ff[vnr_pkg::REM_WIDTH-3:0],
                       acc_ff[vnr_pkg::ACC_WIDTH-1 -: 2]};
   assign trial     = vnr_pkg::REM_WIDTH'({root_ff, 2'b01});
   assign ge        = (rem_shift >= trial);

   always_comb begin
      acc_in      = acc_ff;
      clip_in     = clip_ff;
      at_start_in = at_start_ff;
      rem_in      = rem_ff;
      root_in     = root_ff;
      result_in   = result_ff;
      if (cmd.accept) begin
         at_start_in = 1'b0;
         clip_in     = base_clip;
         rem_in      = '0;
         root_in     = '0;
         case (mode_ff) inside
            vnr_pkg::MODE_L1, vnr_pkg::MODE_L2: begin
               if (sum[vnr_pkg::ACC_WIDTH]) begin
                  acc_in  = '1;
                  clip_in = 1'b1;
               end else begin
                  acc_in = sum[vnr_pkg::ACC_WIDTH-1:0];
               end
            end
            vnr_pkg::MODE_LINF: begin
               acc_in = (vnr_pkg::ACC_WIDTH'(mag) > base) ? vnr_pkg::ACC_WIDTH'(mag) : base;
            end
            default: begin
               acc_in = (at_start_ff || (signed'(sext) > signed'(base))) ? sext : base;
            end
         endcase
      end else if (cmd.root_step) begin
         rem_in  = ge ? (rem_shift - trial) : rem_shift;
         root_in = {root_ff[vnr_pkg::ROOT_WIDTH-2:0], ge};
         acc_in  = acc_ff << 2;
      end else if (cmd.load_out) begin
         case (mode_ff)
            vnr_pkg::MODE_SMAX: result_in = vnr_pkg::RESULT_WIDTH'(signed'(acc_ff));
            vnr_pkg::MODE_L2:   result_in = vnr_pkg::RESULT_WIDTH'(root_ff);
            default:            result_in = vnr_pkg::RESULT_WIDTH'(acc_ff);
         endcase
         acc_in      = '0;
         clip_in     = 1'b0;
         at_start_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= vnr_pkg::MODE_L1;
         acc_ff      <= '0;
         clip_ff     <= 1'b0;
         at_start_ff <= 1'b1;
      end else begin
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
         acc_ff      <= acc_in;
         clip_ff     <= clip_in;
         at_start_ff <= at_start_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff    <= rem_in;
      root_ff   <= root_in;
      result_ff <= result_in;
      if (cmd.load_out) begin
         sat_ff <= clip_ff;
      end
   end

   assign result_value = result_ff;
   assign saturated    = sat_ff;

endmodule

// ===== design/vector_norm_reducer_core.sv =====
// Top level of the vector norm reducer: controller plus datapath.
// Reduces each vector of signed 16-bit samples (tlast closes a vector) to one result word:
// L1 sum, floor square root of the sum of squares, max magnitude or signed max, chosen by
// the 2-bit mode register. Sums saturate at 2^48-1 and flag it in rsp_tuser. Samples are
// taken one per cycle in the run state. After the last sample of a vector, L2 mode first
// runs a restoring square root that produces one root bit per cycle; in every mode the core
// then waits while an earlier result still sits unread in the output register.
module vector_norm_reducer_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [1:0]                          csr_wr_data,   // norm_mode
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [vnr_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,     // [15:0] sample
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [vnr_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,     // [48:0] result_value, zero pad
   output logic [0:0]                          rsp_tuser      // [0] saturated
);

   vnr_pkg::vnr_cmd_type    cmd;
   vnr_pkg::vnr_status_type status;
   logic [vnr_pkg::RESULT_WIDTH-1:0] result_value;
   logic saturated;

   vnr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   vnr_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .sample       (signed'(req_tdata[vnr_pkg::SAMPLE_WIDTH-1:0])),
      .cmd          (cmd),
      .status       (status),
      .result_value (result_value),
      .saturated    (saturated)
   );

   assign rsp_tdata    = vnr_pkg::RSP_DATA_WIDTH'(result_value);
   assign rsp_tuser[0] = saturated;

endmodule
